@@ rtl/core/ibt_pkg.sv @@
// Shared constants, types and codes for the interval booking table.
package ibt_pkg;

  localparam int CAPACITY   = 1024;
  localparam int TIME_BITS  = 30;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int GROUP      = 32;
  localparam int NUM_GROUPS = (CAPACITY + GROUP - 1) / GROUP;

  typedef logic [TIME_BITS-1:0] time_t;

  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2
  } ibt_status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CMP    = 4'b0010,
    S_REDUCE = 4'b0100,
    S_DECIDE = 4'b1000
  } ibt_state_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic cmp;
    logic ins;
  } ibt_ctrl_t;

  // Per-cell hit flags handed to the reduction tree.
  typedef struct packed {
    logic ovl;
    logic eq;
  } ibt_flags_t;

endpackage

@@ rtl/core/ibt_cell.sv @@
// One slot of the sorted interval chain: holds one entry and shifts it on insert.
module ibt_cell
  import ibt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ibt_ctrl_t  ctrl,
  input  logic [IDX_W-1:0] idx,
  input  logic [CNT_W-1:0] count,
  input  time_t      req_start,
  input  time_t      req_end,
  input  logic       prev_after,
  input  logic       next_after,
  input  logic       prev_after_q,
  input  time_t      prev_start,
  input  time_t      prev_end,
  output logic       after,
  output logic       after_q,
  output time_t      start_val,
  output time_t      end_val,
  output ibt_flags_t flags
);

  time_t start_q;
  time_t end_q;
  logic  valid;
  logic  succ;
  logic  pred;
  logic  ovl_next;
  logic  eq_next;

  assign valid = CNT_W'(idx) < count;

  // Entries are sorted and packed at the low end, so "after" is a step from 0 to 1
  // along the chain and the step marks the insertion point.
  assign after = !valid || (start_q >= req_start);
  assign succ  = valid && after && !prev_after;
  assign pred  = valid && !after && next_after;

  assign ovl_next = (succ && (req_end > start_q)) || (pred && (end_q > req_start));
  assign eq_next  = succ && (start_q == req_start);

  always_ff @(posedge clk) begin
    if (rst) begin
      flags   <= '0;
      after_q <= 1'b0;
    end else if (ctrl.cmp) begin
      flags.ovl <= ovl_next;
      flags.eq  <= eq_next;
      after_q   <= after;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins && after_q) begin
      if (prev_after_q) begin
        start_q <= prev_start;
        end_q   <= prev_end;
      end else begin
        start_q <= req_start;
        end_q   <= req_end;
      end
    end
  end

  assign start_val = start_q;
  assign end_val   = end_q;

endmodule

@@ rtl/core/ibt_reduce.sv @@
// Registered OR of one group of cell hit flags.
module ibt_reduce
  import ibt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [GROUP-1:0] ovl,
  input  logic [GROUP-1:0] eq,
  output logic             any_ovl,
  output logic             any_eq
);

  always_ff @(posedge clk) begin
    if (rst) begin
      any_ovl <= 1'b0;
      any_eq  <= 1'b0;
    end else begin
      any_ovl <= |ovl;
      any_eq  <= |eq;
    end
  end

endmodule

@@ rtl/core/interval_booking_table_top.sv @@
// Interval booking table: a sorted chain of cells with an overlap check per request.
// Each request runs through compare in the cells, the OR tree and decide, in that order; busy is high
// while a request is in flight, up to and including its result, so no new request is taken before the last is decided.
// The result strobe done is high for one cycle, in the decide step, and cannot stall.
// An accepted insert shifts the later entries one cell along the chain at the clock edge that ends done.
// Synchronous reset empties the table (entry count to zero) and returns the block to idle.
module interval_booking_table_top
  import ibt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] start_time,
  input  logic [TIME_BITS-1:0] end_time,
  output logic                 busy,
  output logic                 done,
  output logic [1:0]           status
);

  ibt_state_t state;
  ibt_state_t state_next;
  time_t      req_start;
  time_t      req_end;
  logic [CNT_W-1:0] count;
  ibt_ctrl_t  ctrl;
  ibt_status_t result;
  logic       any_ovl;
  logic       any_eq;
  logic       full;

  logic       after   [CAPACITY];
  logic       after_q [CAPACITY];
  time_t      cell_start [CAPACITY];
  time_t      cell_end   [CAPACITY];
  ibt_flags_t flags   [CAPACITY];

  logic [GROUP-1:0] grp_ovl_in [NUM_GROUPS];
  logic [GROUP-1:0] grp_eq_in  [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] grp_ovl;
  logic [NUM_GROUPS-1:0] grp_eq;

  wire accept = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_CMP;
      S_CMP:    state_next = S_REDUCE;
      S_REDUCE: state_next = S_DECIDE;
      S_DECIDE: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_start <= start_time;
      req_end   <= end_time;
    end
  end

  assign any_ovl = |grp_ovl;
  assign any_eq  = |grp_eq;
  assign full    = count == CNT_W'(CAPACITY);

  always_comb begin
    if (any_ovl) begin
      result = ST_OVERLAP;
    end else if (any_eq) begin
      result = ST_BOOKED;
    end else if (full) begin
      result = ST_FULL;
    end else begin
      result = ST_BOOKED;
    end
  end

  assign busy     = state != S_IDLE;
  assign done     = state == S_DECIDE;
  assign status   = result;
  assign ctrl.cmp = state == S_CMP;
  assign ctrl.ins = done && !any_ovl && !any_eq && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.ins) begin
      count <= count + CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic  prev_after;
    logic  next_after;
    logic  prev_after_q;
    time_t prev_start;
    time_t prev_end;

    if (i == 0) begin : g_first
      assign prev_after   = 1'b0;
      assign prev_after_q = 1'b0;
      assign prev_start   = req_start;
      assign prev_end     = req_end;
    end else begin : g_link
      assign prev_after   = after[i-1];
      assign prev_after_q = after_q[i-1];
      assign prev_start   = cell_start[i-1];
      assign prev_end     = cell_end[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_after = 1'b1;
    end else begin : g_mid
      assign next_after = after[i+1];
    end

    ibt_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .idx          (IDX_W'(i)),
      .count        (count),
      .req_start    (req_start),
      .req_end      (req_end),
      .prev_after   (prev_after),
      .next_after   (next_after),
      .prev_after_q (prev_after_q),
      .prev_start   (prev_start),
      .prev_end     (prev_end),
      .after        (after[i]),
      .after_q      (after_q[i]),
      .start_val    (cell_start[i]),
      .end_val      (cell_end[i]),
      .flags        (flags[i])
    );
  end

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
    for (genvar k = 0; k < GROUP; k++) begin : g_bit
      if (g * GROUP + k < CAPACITY) begin : g_used
        assign grp_ovl_in[g][k] = flags[g*GROUP+k].ovl;
        assign grp_eq_in[g][k]  = flags[g*GROUP+k].eq;
      end else begin : g_pad
        assign grp_ovl_in[g][k] = 1'b0;
        assign grp_eq_in[g][k]  = 1'b0;
      end
    end

    ibt_reduce u_reduce (
      .clk     (clk),
      .rst     (rst),
      .ovl     (grp_ovl_in[g]),
      .eq      (grp_eq_in[g]),
      .any_ovl (grp_ovl[g]),
      .any_eq  (grp_eq[g])
    );
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !done)
    else $error("transfer did not start a request");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block stayed busy after its result");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_BOOKED || status == ST_OVERLAP || status == ST_FULL))
    else $error("result carries an undefined status");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      ($past(done) && $past(status) == ST_BOOKED && count == $past(count) + CNT_W'(1)))
    else $error("entry count changed without a booking");

endmodule

@@ test/tb_interval_booking_table_top.sv @@
// Self-checking testbench for the interval booking table: request stimulus and status check.
`timescale 1ns / 1ps

module tb_interval_booking_table_top;
  import ibt_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int FILL_TRIES   = 4096;
  localparam int FILL_STRIDE  = 64;
  localparam int FILL_LEN     = 16;
  localparam int WINDOW       = 4095;
  localparam time_t FILL_BASE = time_t'(30'h3000_0000);
  localparam time_t TIME_MAX  = {TIME_BITS{1'b1}};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  time_t      start_time = '0;
  time_t      end_time = '0;
  logic       busy;
  logic       done;
  logic [1:0] status;

  // Predicted contents of the table, sorted by start time.
  time_t booked_start [CAPACITY];
  time_t booked_end [CAPACITY];
  int    booked_count = 0;

  ibt_status_t expected_status[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          steady_left = 0;

  interval_booking_table_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_time (start_time),
    .end_time   (end_time),
    .busy       (busy),
    .done       (done),
    .status     (status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_interval_booking_table_top: done, errors");
      $finish;
    end
  end

  // Applies one request to the predicted table and returns the status it earns.
  function automatic ibt_status_t book_request(input time_t s, input time_t e);
    int pos;
    int i;
    pos = 0;
    while (pos < booked_count && booked_start[pos] < s) pos++;
    if (pos < booked_count && e > booked_start[pos]) return ST_OVERLAP;
    if (pos > 0 && s < booked_end[pos-1]) return ST_OVERLAP;
    if (pos < booked_count && booked_start[pos] == s) return ST_BOOKED;
    if (booked_count >= CAPACITY) return ST_FULL;
    for (i = booked_count; i > pos; i--) begin
      booked_start[i] = booked_start[i-1];
      booked_end[i]   = booked_end[i-1];
    end
    booked_start[pos] = s;
    booked_end[pos]   = e;
    booked_count++;
    return ST_BOOKED;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      steady_left = $urandom_range(10, 30);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Draws one request, mostly clustered in a small window so that overlaps,
  // touching neighbors and repeated keys are common.
  function automatic void draw_request(output time_t s, output time_t e);
    int pick;
    int idx;
    pick = $urandom_range(99);
    if (pick < 45) begin
      s = time_t'($urandom_range(WINDOW));
      e = s + time_t'($urandom_range(48));
    end else if (pick < 60 && booked_count > 0) begin
      idx = $urandom_range(booked_count - 1);
      s = booked_start[idx];
      case ($urandom_range(2))
        0: e = s;
        1: e = s - time_t'($urandom_range(1, 500));
        default: e = s + time_t'($urandom_range(1, 20));
      endcase
    end else if (pick < 75 && booked_count > 0) begin
      // Touch the end of a stored interval, sometimes also the next start.
      idx = $urandom_range(booked_count - 1);
      s = booked_end[idx];
      if (idx + 1 < booked_count && $urandom_range(1))
        e = booked_start[idx+1];
      else
        e = s + time_t'($urandom_range(0, 30));
    end else if (pick < 85) begin
      s = time_t'($urandom_range(WINDOW));
      e = s - time_t'($urandom_range(0, 64));
    end else if (pick < 95) begin
      s = time_t'($urandom);
      e = time_t'($urandom);
      if (e > s && e - s > 1000) e = s + time_t'($urandom_range(1000));
    end else begin
      s = time_t'($urandom_range(4096, 1 << 20));
      e = s + time_t'($urandom_range(1 << 14));
    end
  endfunction

  // Presents one request and waits for its transfer; start stays high when
  // the next request follows without a gap.
  task automatic send_request(input time_t s, input time_t e);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    start_time <= s;
    end_time   <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_status.push_back(book_request(s, e));
  endtask

  always @(posedge clk) begin
    ibt_status_t want;
    if (!rst && done) begin
      if (expected_status.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("ERROR: result with no request pending, status %0d", status);
      end else begin
        want = expected_status.pop_front();
        if (status !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: status expected %0d, got %0d", want, status);
        end
      end
    end
  end

  task automatic test_directed();
    send_request(100, 200);
    send_request(200, 300);
    send_request(50, 100);
    send_request(150, 160);
    send_request(99, 101);
    send_request(100, 150);
    send_request(100, 100);
    send_request(300, 300);
    send_request(250, 250);
    send_request(400, 350);
    send_request(399, 401);
    send_request(0, 0);
    send_request(0, 50);
    send_request(TIME_MAX, TIME_MAX);
    send_request(time_t'(TIME_MAX - time_t'(1)), TIME_MAX);
    send_request(0, TIME_MAX);
    send_request(TIME_MAX, 0);
    send_request(time_t'(30'h2AAA_AAAA), time_t'(30'h1555_5555));
    send_request(time_t'(30'h1555_5555), time_t'(30'h2AAA_AAAA));
    send_request(time_t'(30'h1555_5560), time_t'(30'h1555_5570));
    send_request(time_t'(30'h2AAA_AAAA), time_t'(30'h2AAA_AAAA));
  endtask

  task automatic test_random(input int count);
    time_t s;
    time_t e;
    for (int n = 0; n < count; n++) begin
      draw_request(s, e);
      send_request(s, e);
    end
  endtask

  // Packs short disjoint intervals into a quiet region until the table is full.
  task automatic test_fill_to_capacity();
    time_t s;
    for (int k = 0; k < FILL_TRIES && booked_count < CAPACITY; k++) begin
      s = FILL_BASE + time_t'(k * FILL_STRIDE);
      send_request(s, s + time_t'(FILL_LEN));
    end
  endtask

  task automatic test_full_table();
    send_request(FILL_BASE - time_t'(100000), FILL_BASE - time_t'(99990));
    send_request(FILL_BASE, FILL_BASE);
    send_request(FILL_BASE + time_t'(4), FILL_BASE + time_t'(8));
    send_request(FILL_BASE + time_t'(FILL_LEN), FILL_BASE + time_t'(FILL_STRIDE));
    send_request(TIME_MAX - time_t'(5), TIME_MAX - time_t'(7));
    test_random(20);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(RANDOM_ITEMS);
    test_fill_to_capacity();
    test_full_table();
    start <= 1'b0;
    while (expected_status.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("tb_interval_booking_table_top: done, clean");
    else
      $display("tb_interval_booking_table_top: done, errors");
    $finish;
  end

endmodule
